// ===== src/arp_pkg.sv =====
// shared types and constants for the arp resolver
package arp_pkg;

  localparam logic [1:0] FUNC_SEND = 2'd0;
  localparam logic [1:0] FUNC_RECV = 2'd1;
  localparam logic [1:0] FUNC_TICK = 2'd2;

  localparam logic [1:0] FT_IPV4 = 2'd0;
  localparam logic [1:0] FT_ARP  = 2'd1;

  localparam logic [1:0] OP_REQUEST = 2'd0;
  localparam logic [1:0] OP_REPLY   = 2'd1;

  localparam logic [2:0] KIND_IPV4      = 3'd0;
  localparam logic [2:0] KIND_ARP_REQ   = 3'd1;
  localparam logic [2:0] KIND_ARP_REPLY = 3'd2;
  localparam logic [2:0] KIND_DELIVER   = 3'd3;
  localparam logic [2:0] KIND_DROP      = 3'd4;

  localparam logic [1:0] CFG_OWN_MAC  = 2'd0;
  localparam logic [1:0] CFG_OWN_IP   = 2'd1;
  localparam logic [1:0] CFG_LIFETIME = 2'd2;
  localparam logic [1:0] CFG_HOLDOFF  = 2'd3;

  localparam logic [15:0] LIFETIME_RST = 16'd30000;
  localparam logic [15:0] HOLDOFF_RST  = 16'd5000;
  localparam logic [47:0] BCAST_MAC    = 48'hFFFF_FFFF_FFFF;

  typedef enum logic [3:0] {
    ST_IDLE, ST_CSCAN, ST_PSCAN, ST_AGEC, ST_AGEP,
    ST_WRD, ST_WEV, ST_WEND, ST_EMIT
  } state_t;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] next_hop_ip;
    logic [15:0] handle;
    logic [47:0] dest_mac;
    logic [1:0]  frame_type;
    logic        parse_ok;
    logic [1:0]  arp_opcode;
    logic [47:0] sender_mac;
    logic [31:0] sender_ip;
    logic [31:0] target_ip;
    logic [15:0] elapsed_ms;
  } req_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [47:0] dest_mac;
    logic [15:0] handle;
    logic [47:0] target_mac;
    logic [31:0] target_ip;
    logic        last;
  } res_t;

  typedef struct packed {
    logic [47:0] own_mac;
    logic [31:0] own_ip;
    logic [15:0] cache_lifetime;
    logic [15:0] request_holdoff;
  } cfg_t;

endpackage

// ===== src/arp_resolver_with_aging_unit.sv =====
// top level of the arp resolver: configuration registers, engine and output register
//
// usage: one input channel (in_valid / in_ready) carries a send request, a
// received frame or a time tick; one result channel (out_valid / out_ready)
// carries the items each input causes, with last set on the final one. an
// input may cause no result at all (filtered frame, tick, cached arp update).
// configuration is written through cfg_we / cfg_index / cfg_data while idle (by the user; not enforced).
// the engine handles one input at a time; in_ready is high only when it idles.
// processing of each input kind:
//   send: one cache scan then one pending scan, one memory read per entry per cycle
//   received ipv4 frame: result emitted directly; arp frame: one cache scan,
//         plus on a reply a wait store compaction pass over the queued datagrams
//         (a read and an evaluate state per datagram) with an emit state per
//         released datagram
//   tick: aging read-modify-write of cache then pending table, one entry a cycle
// the scans of the table memories set the processing time of each input.
// results pass through one output register; when the receiver stalls the
// engine holds its current result and stops until it is taken.
// reset (rst, synchronous) empties the cache, pending table and wait store
// and loads the default lifetimes; memory contents are not cleared.
module arp_resolver_with_aging_unit #(
  parameter int CACHE_ENTRIES   = 16,
  parameter int PENDING_ENTRIES = 16,
  parameter int WAIT_SLOTS      = 16
) (
  input  logic        clk,
  input  logic        rst,
  // configuration write port
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [47:0] cfg_data,
  // input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  func,
  input  logic [31:0] next_hop_ip,
  input  logic [15:0] datagram_handle,
  input  logic [47:0] dest_mac,
  input  logic [1:0]  frame_type,
  input  logic        parse_ok,
  input  logic [1:0]  arp_opcode,
  input  logic [47:0] sender_mac,
  input  logic [31:0] sender_ip,
  input  logic [31:0] target_ip,
  input  logic [15:0] elapsed_ms,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_kind,
  output logic [47:0] out_dest_mac,
  output logic [15:0] out_handle,
  output logic [47:0] out_target_mac,
  output logic [31:0] out_target_ip,
  output logic        last
);

  arp_pkg::cfg_t cfg;
  arp_pkg::req_t req;
  arp_pkg::res_t eng_res, out_res;
  logic          eng_valid, eng_ready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.own_mac         <= '0;
      cfg.own_ip          <= '0;
      cfg.cache_lifetime  <= arp_pkg::LIFETIME_RST;
      cfg.request_holdoff <= arp_pkg::HOLDOFF_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        arp_pkg::CFG_OWN_MAC:  cfg.own_mac         <= cfg_data;
        arp_pkg::CFG_OWN_IP:   cfg.own_ip          <= cfg_data[31:0];
        arp_pkg::CFG_LIFETIME: cfg.cache_lifetime  <= cfg_data[15:0];
        arp_pkg::CFG_HOLDOFF:  cfg.request_holdoff <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // bundle the input fields
  assign req = '{func: func, next_hop_ip: next_hop_ip, handle: datagram_handle,
                 dest_mac: dest_mac, frame_type: frame_type, parse_ok: parse_ok,
                 arp_opcode: arp_opcode, sender_mac: sender_mac, sender_ip: sender_ip,
                 target_ip: target_ip, elapsed_ms: elapsed_ms};

  arp_engine #(
    .CACHE_ENTRIES  (CACHE_ENTRIES),
    .PENDING_ENTRIES(PENDING_ENTRIES),
    .WAIT_SLOTS     (WAIT_SLOTS)
  ) u_engine (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .req_valid(in_valid),
    .req_ready(in_ready),
    .req      (req),
    .res_valid(eng_valid),
    .res_ready(eng_ready),
    .res      (eng_res)
  );

  // result register decouples engine from a stalling receiver
  arp_outreg u_outreg (
    .clk      (clk),
    .rst      (rst),
    .res_valid(eng_valid),
    .res_ready(eng_ready),
    .res      (eng_res),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_res  (out_res)
  );

  assign out_kind       = out_res.kind;
  assign out_dest_mac   = out_res.dest_mac;
  assign out_handle     = out_res.handle;
  assign out_target_mac = out_res.target_mac;
  assign out_target_ip  = out_res.target_ip;
  assign last           = out_res.last;

endmodule

// ===== src/arp_outreg.sv =====
// output register between the engine and the result channel
module arp_outreg (
  input  logic          clk,
  input  logic          rst,
  input  logic          res_valid,
  output logic          res_ready,
  input  arp_pkg::res_t res,
  output logic          out_valid,
  input  logic          out_ready,
  output arp_pkg::res_t out_res
);

  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res <= res;
    end
  end

endmodule

// ===== src/arp_engine.sv =====
// table memories and the sequencer that scans, ages and compacts them
module arp_engine #(
  parameter int CACHE_ENTRIES   = 16,
  parameter int PENDING_ENTRIES = 16,
  parameter int WAIT_SLOTS      = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  arp_pkg::cfg_t cfg,
  input  logic          req_valid,
  output logic          req_ready,
  input  arp_pkg::req_t req,
  output logic          res_valid,
  input  logic          res_ready,
  output arp_pkg::res_t res
);

  localparam int CIW  = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
  localparam int PIW  = (PENDING_ENTRIES > 1) ? $clog2(PENDING_ENTRIES) : 1;
  localparam int WIW  = (WAIT_SLOTS > 1) ? $clog2(WAIT_SLOTS) : 1;
  localparam int MAXCP = (CACHE_ENTRIES > PENDING_ENTRIES) ? CACHE_ENTRIES : PENDING_ENTRIES;
  localparam int MAXN = (MAXCP > WAIT_SLOTS) ? MAXCP : WAIT_SLOTS;
  localparam int SW   = $clog2(MAXN + 1);
  localparam int WCW  = $clog2(WAIT_SLOTS + 1);
  localparam logic [SW-1:0]  C_END = SW'(CACHE_ENTRIES);
  localparam logic [SW-1:0]  P_END = SW'(PENDING_ENTRIES);
  localparam logic [WCW-1:0] W_MAX = WCW'(WAIT_SLOTS);

  arp_pkg::state_t state, state_next, ret_state;
  arp_pkg::req_t   req_q;
  arp_pkg::res_t   res_q;

  logic [SW-1:0] sidx, pidx, hit_idx, free_idx, best_idx, slot, end_val;
  logic          pv, hit, free_found, drop_pend, held;
  logic [47:0]   hit_mac;
  logic [15:0]   best_age, held_handle;
  logic [CACHE_ENTRIES-1:0]   cvalid;
  logic [PENDING_ENTRIES-1:0] pvalid;
  logic [WCW-1:0] wcount, wi, wk;

  // memories
  logic [31:0] cache_ip   [CACHE_ENTRIES];
  logic [47:0] cache_mac  [CACHE_ENTRIES];
  logic [15:0] cache_age  [CACHE_ENTRIES];
  logic [31:0] pending_ip [PENDING_ENTRIES];
  logic [15:0] pending_age[PENDING_ENTRIES];
  logic [31:0] wait_ip    [WAIT_SLOTS];
  logic [15:0] wait_handle[WAIT_SLOTS];
  logic [31:0] c_ip_q, p_ip_q, w_ip_q;
  logic [47:0] c_mac_q;
  logic [15:0] c_age_q, p_age_q, w_h_q;

  logic          c_wr, c_age_wr, p_wr, p_age_wr, w_wr;
  logic [CIW-1:0] c_waddr, c_age_waddr;
  logic [PIW-1:0] p_waddr, p_age_waddr;
  logic [WIW-1:0] w_waddr;
  logic [15:0]   c_age_wdata, p_age_wdata;
  logic [31:0]   w_ip_wdata;
  logic [15:0]   w_h_wdata;

  logic          is_scan, issue, scan_end, is_send, recv_ok, room;
  logic          ev_valid, ev_match, reply_own, w_match;
  logic [31:0]   ev_ip, target;
  logic [15:0]   ev_age, limit;
  logic [16:0]   age_sum;
  logic          expire;
  arp_pkg::state_t w_nxt;

  assign req_ready = (state == arp_pkg::ST_IDLE);
  assign res_valid = (state == arp_pkg::ST_EMIT);
  assign res       = res_q;

  assign recv_ok = (req.dest_mac == arp_pkg::BCAST_MAC || req.dest_mac == cfg.own_mac)
                   && req.parse_ok;
  assign is_send = (req_q.func == arp_pkg::FUNC_SEND);
  assign target  = is_send ? req_q.next_hop_ip : req_q.sender_ip;
  assign room    = (wcount < W_MAX);
  assign reply_own = (req_q.arp_opcode == arp_pkg::OP_REQUEST)
                     && (req_q.target_ip == cfg.own_ip);
  assign slot    = hit ? hit_idx : (free_found ? free_idx : best_idx);
  assign w_match = (w_ip_q == req_q.sender_ip);
  assign w_nxt   = ((wi + WCW'(1)) == wcount) ? arp_pkg::ST_WEND : arp_pkg::ST_WRD;

  always_comb begin
    is_scan = 1'b0;
    end_val = C_END;
    case (state)
      arp_pkg::ST_CSCAN, arp_pkg::ST_AGEC: begin
        is_scan = 1'b1;
      end
      arp_pkg::ST_PSCAN, arp_pkg::ST_AGEP: begin
        is_scan = 1'b1;
        end_val = P_END;
      end
      default: ;
    endcase
  end

  assign issue    = is_scan && (sidx != end_val);
  assign scan_end = is_scan && (sidx == end_val) && !pv;

  always_comb begin
    if (state == arp_pkg::ST_CSCAN || state == arp_pkg::ST_AGEC) begin
      ev_valid = cvalid[pidx[CIW-1:0]];
      ev_ip    = c_ip_q;
      ev_age   = c_age_q;
      limit    = cfg.cache_lifetime;
    end else begin
      ev_valid = pvalid[pidx[PIW-1:0]];
      ev_ip    = p_ip_q;
      ev_age   = p_age_q;
      limit    = cfg.request_holdoff;
    end
  end

  assign ev_match = ev_valid && (ev_ip == target);
  assign age_sum  = {1'b0, ev_age} + {1'b0, req_q.elapsed_ms};
  assign expire   = age_sum > {1'b0, limit};

  // next state
  always_comb begin
    state_next = state;
    case (state)
      arp_pkg::ST_IDLE: begin
        if (req_valid) begin
          case (req.func)
            arp_pkg::FUNC_SEND: state_next = arp_pkg::ST_CSCAN;
            arp_pkg::FUNC_RECV: begin
              if (recv_ok && req.frame_type == arp_pkg::FT_IPV4) begin
                state_next = arp_pkg::ST_EMIT;
              end else if (recv_ok && req.frame_type == arp_pkg::FT_ARP) begin
                state_next = arp_pkg::ST_CSCAN;
              end
            end
            arp_pkg::FUNC_TICK: state_next = arp_pkg::ST_AGEC;
            default: ;
          endcase
        end
      end
      arp_pkg::ST_CSCAN: begin
        if (scan_end) begin
          if (is_send) begin
            state_next = hit ? arp_pkg::ST_EMIT : arp_pkg::ST_PSCAN;
          end else if (reply_own) begin
            state_next = arp_pkg::ST_EMIT;
          end else if (req_q.arp_opcode == arp_pkg::OP_REPLY) begin
            state_next = (wcount == '0) ? arp_pkg::ST_WEND : arp_pkg::ST_WRD;
          end else begin
            state_next = arp_pkg::ST_IDLE;
          end
        end
      end
      arp_pkg::ST_PSCAN: begin
        if (scan_end) begin
          state_next = (!hit || !room) ? arp_pkg::ST_EMIT : arp_pkg::ST_IDLE;
        end
      end
      arp_pkg::ST_AGEC: if (scan_end) state_next = arp_pkg::ST_AGEP;
      arp_pkg::ST_AGEP: if (scan_end) state_next = arp_pkg::ST_IDLE;
      arp_pkg::ST_WRD: state_next = arp_pkg::ST_WEV;
      arp_pkg::ST_WEV: state_next = (w_match && held) ? arp_pkg::ST_EMIT : w_nxt;
      arp_pkg::ST_WEND: state_next = held ? arp_pkg::ST_EMIT : arp_pkg::ST_IDLE;
      arp_pkg::ST_EMIT: begin
        if (res_ready && !drop_pend) state_next = ret_state;
      end
      default: state_next = arp_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= arp_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // memory write ports
  always_comb begin
    c_wr        = (state == arp_pkg::ST_CSCAN) && scan_end && !is_send;
    c_waddr     = slot[CIW-1:0];
    c_age_wr    = c_wr;
    c_age_waddr = slot[CIW-1:0];
    c_age_wdata = '0;
    if (state == arp_pkg::ST_AGEC && pv) begin
      c_age_wr    = ev_valid && !expire;
      c_age_waddr = pidx[CIW-1:0];
      c_age_wdata = age_sum[15:0];
    end
    p_wr        = (state == arp_pkg::ST_PSCAN) && scan_end && !hit;
    p_waddr     = slot[PIW-1:0];
    p_age_wr    = p_wr;
    p_age_waddr = slot[PIW-1:0];
    p_age_wdata = '0;
    if (state == arp_pkg::ST_AGEP && pv) begin
      p_age_wr    = ev_valid && !expire;
      p_age_waddr = pidx[PIW-1:0];
      p_age_wdata = age_sum[15:0];
    end
    w_wr       = (state == arp_pkg::ST_PSCAN) && scan_end && room;
    w_waddr    = wcount[WIW-1:0];
    w_ip_wdata = req_q.next_hop_ip;
    w_h_wdata  = req_q.handle;
    if (state == arp_pkg::ST_WEV) begin
      w_wr       = !w_match;
      w_waddr    = wk[WIW-1:0];
      w_ip_wdata = w_ip_q;
      w_h_wdata  = w_h_q;
    end
  end

  always_ff @(posedge clk) begin
    if (c_wr) begin
      cache_ip[c_waddr]  <= req_q.sender_ip;
      cache_mac[c_waddr] <= req_q.sender_mac;
    end
    if (c_age_wr) begin
      cache_age[c_age_waddr] <= c_age_wdata;
    end
    c_ip_q  <= cache_ip[sidx[CIW-1:0]];
    c_mac_q <= cache_mac[sidx[CIW-1:0]];
    c_age_q <= cache_age[sidx[CIW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (p_wr) begin
      pending_ip[p_waddr] <= req_q.next_hop_ip;
    end
    if (p_age_wr) begin
      pending_age[p_age_waddr] <= p_age_wdata;
    end
    p_ip_q  <= pending_ip[sidx[PIW-1:0]];
    p_age_q <= pending_age[sidx[PIW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (w_wr) begin
      wait_ip[w_waddr]     <= w_ip_wdata;
      wait_handle[w_waddr] <= w_h_wdata;
    end
    w_ip_q <= wait_ip[wi[WIW-1:0]];
    w_h_q  <= wait_handle[wi[WIW-1:0]];
  end

  // datapath and flag registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cvalid    <= '0;
      pvalid    <= '0;
      wcount    <= '0;
      drop_pend <= 1'b0;
      held      <= 1'b0;
      pv        <= 1'b0;
      ret_state <= arp_pkg::ST_IDLE;
    end else begin
      if (state != arp_pkg::ST_EMIT) begin
        ret_state <= (state == arp_pkg::ST_WEV) ? w_nxt : arp_pkg::ST_IDLE;
      end
      case (state)
        arp_pkg::ST_IDLE: begin
          req_q      <= req;
          sidx       <= '0;
          pv         <= 1'b0;
          hit        <= 1'b0;
          free_found <= 1'b0;
          res_q      <= '{kind: arp_pkg::KIND_DELIVER, dest_mac: '0, handle: req.handle,
                          target_mac: '0, target_ip: '0, last: 1'b1};
        end
        arp_pkg::ST_CSCAN, arp_pkg::ST_PSCAN, arp_pkg::ST_AGEC, arp_pkg::ST_AGEP: begin
          if (issue) sidx <= sidx + SW'(1);
          pv   <= issue;
          pidx <= sidx;
          if (pv) begin
            if (state == arp_pkg::ST_CSCAN || state == arp_pkg::ST_PSCAN) begin
              if (ev_match) begin
                hit     <= 1'b1;
                hit_idx <= pidx;
                hit_mac <= c_mac_q;
              end
              if (!ev_valid && !free_found) begin
                free_found <= 1'b1;
                free_idx   <= pidx;
              end
              if (pidx == '0 || ev_age > best_age) begin
                best_idx <= pidx;
                best_age <= ev_age;
              end
            end else if (state == arp_pkg::ST_AGEC) begin
              if (ev_valid && expire) cvalid[pidx[CIW-1:0]] <= 1'b0;
            end else begin
              if (ev_valid && expire) pvalid[pidx[PIW-1:0]] <= 1'b0;
            end
          end
          if (scan_end) begin
            sidx       <= '0;
            hit        <= 1'b0;
            free_found <= 1'b0;
            case (state)
              arp_pkg::ST_CSCAN: begin
                if (is_send) begin
                  res_q <= '{kind: arp_pkg::KIND_IPV4, dest_mac: hit_mac,
                             handle: req_q.handle, target_mac: '0, target_ip: '0,
                             last: 1'b1};
                end else begin
                  cvalid[slot[CIW-1:0]] <= 1'b1;
                  res_q <= '{kind: arp_pkg::KIND_ARP_REPLY, dest_mac: req_q.sender_mac,
                             handle: '0, target_mac: req_q.sender_mac,
                             target_ip: req_q.sender_ip, last: 1'b1};
                  wi   <= '0;
                  wk   <= '0;
                  held <= 1'b0;
                end
              end
              arp_pkg::ST_PSCAN: begin
                if (room) wcount <= wcount + WCW'(1);
                if (!hit) begin
                  pvalid[slot[PIW-1:0]] <= 1'b1;
                  drop_pend <= !room;
                  res_q <= '{kind: arp_pkg::KIND_ARP_REQ, dest_mac: arp_pkg::BCAST_MAC,
                             handle: '0, target_mac: '0, target_ip: req_q.next_hop_ip,
                             last: room};
                end else begin
                  res_q <= '{kind: arp_pkg::KIND_DROP, dest_mac: '0,
                             handle: req_q.handle, target_mac: '0, target_ip: '0,
                             last: 1'b1};
                end
              end
              default: ;
            endcase
          end
        end
        arp_pkg::ST_WEV: begin
          wi <= wi + WCW'(1);
          if (w_match) begin
            held        <= 1'b1;
            held_handle <= w_h_q;
            if (held) begin
              res_q <= '{kind: arp_pkg::KIND_IPV4, dest_mac: req_q.sender_mac,
                         handle: held_handle, target_mac: '0, target_ip: '0, last: 1'b0};
            end
          end else begin
            wk <= wk + WCW'(1);
          end
        end
        arp_pkg::ST_WEND: begin
          wcount <= wk;
          held   <= 1'b0;
          res_q  <= '{kind: arp_pkg::KIND_IPV4, dest_mac: req_q.sender_mac,
                      handle: held_handle, target_mac: '0, target_ip: '0, last: 1'b1};
        end
        arp_pkg::ST_EMIT: begin
          if (res_ready && drop_pend) begin
            drop_pend <= 1'b0;
            res_q <= '{kind: arp_pkg::KIND_DROP, dest_mac: '0, handle: req_q.handle,
                       target_mac: '0, target_ip: '0, last: 1'b1};
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== tb/tb_arp_resolver_with_aging_unit.sv =====
// self-checking testbench for the arp resolver with aging
`timescale 1ns / 100ps

module tb_arp_resolver_with_aging_unit;

  localparam int NCACHE = 16;
  localparam int NPEND = 16;
  localparam int NWAIT = 16;
  localparam int DRAIN_CYCLES = 120;   // margin for the engine to finish its scans and compaction
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int HOLD_CYCLES = 400;
  localparam int ITEMS_PER_PHASE = 20;

  // one row of the directed table: optional hand-typed single result
  typedef struct {
    arp_pkg::req_t r;
    bit            typed;
    arp_pkg::res_t res;
  } row_t;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [47:0] cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  func;
  logic [31:0] next_hop_ip;
  logic [15:0] datagram_handle;
  logic [47:0] dest_mac;
  logic [1:0]  frame_type;
  logic        parse_ok;
  logic [1:0]  arp_opcode;
  logic [47:0] sender_mac;
  logic [31:0] sender_ip;
  logic [31:0] target_ip;
  logic [15:0] elapsed_ms;
  logic        out_valid;
  logic        out_ready;
  logic [2:0]  out_kind;
  logic [47:0] out_dest_mac;
  logic [15:0] out_handle;
  logic [47:0] out_target_mac;
  logic [31:0] out_target_ip;
  logic        last;

  arp_resolver_with_aging_unit dut (.*);

  // predictor state: configuration copy and tables
  logic [47:0] my_mac;
  logic [31:0] my_ip;
  logic [15:0] lifetime, holdoff;
  bit          ch_valid [NCACHE];
  logic [31:0] ch_ip    [NCACHE];
  logic [47:0] ch_mac   [NCACHE];
  logic [15:0] ch_age   [NCACHE];
  bit          pd_valid [NPEND];
  logic [31:0] pd_ip    [NPEND];
  logic [15:0] pd_age   [NPEND];
  int          wq_count;
  logic [31:0] wq_ip    [NWAIT];
  logic [15:0] wq_handle[NWAIT];

  arp_pkg::res_t expected_results[$];
  int   mismatches;
  int   snd_pct, rcv_pct;
  int   hold_gen, hold_seen, hold_cnt;
  int   quiet_cycles;

  logic [31:0] ip_pool [20];
  logic [47:0] mac_pool[20];

  // clock, 20 ns period
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic arp_pkg::res_t mk(logic [2:0] k, logic [47:0] dm, logic [15:0] h,
                                       logic [47:0] tm, logic [31:0] ti);
    arp_pkg::res_t x;
    x.kind = k;
    x.dest_mac = dm;
    x.handle = h;
    x.target_mac = tm;
    x.target_ip = ti;
    x.last = 1'b0;
    return x;
  endfunction

  function automatic int cache_lookup(logic [31:0] ip);
    for (int i = 0; i < NCACHE; i++) if (ch_valid[i] && ch_ip[i] == ip) return i;
    return -1;
  endfunction

  // free slot first, else the oldest entry, lowest index on a tie
  function automatic int pick_slot(bit v[16], logic [15:0] a[16]);
    int best;
    best = 0;
    for (int i = 0; i < 16; i++) if (!v[i]) return i;
    for (int i = 1; i < 16; i++) if (a[i] > a[best]) best = i;
    return best;
  endfunction

  // work out the results of one accepted item and update the tables
  task automatic resolve_item(input arp_pkg::req_t r, input bit typed,
                              input arp_pkg::res_t typed_res);
    arp_pkg::res_t q[$];
    int c, p, k;
    logic [16:0] s;
    c = -1;
    p = -1;
    k = 0;
    case (r.func)
      arp_pkg::FUNC_SEND: begin
        c = cache_lookup(r.next_hop_ip);
        if (c >= 0) begin
          q.push_back(mk(arp_pkg::KIND_IPV4, ch_mac[c], r.handle, '0, '0));
        end else begin
          for (int i = 0; i < NPEND; i++)
            if (p < 0 && pd_valid[i] && pd_ip[i] == r.next_hop_ip) p = i;
          if (p < 0) begin
            p = pick_slot(pd_valid, pd_age);
            pd_valid[p] = 1'b1;
            pd_ip[p] = r.next_hop_ip;
            pd_age[p] = '0;
            q.push_back(mk(arp_pkg::KIND_ARP_REQ, arp_pkg::BCAST_MAC, '0, '0,
                           r.next_hop_ip));
          end
          if (wq_count < NWAIT) begin
            wq_ip[wq_count] = r.next_hop_ip;
            wq_handle[wq_count] = r.handle;
            wq_count++;
          end else begin
            q.push_back(mk(arp_pkg::KIND_DROP, '0, r.handle, '0, '0));
          end
        end
      end
      arp_pkg::FUNC_RECV: begin
        // frame filter on mac address and parse status
        if ((r.dest_mac == arp_pkg::BCAST_MAC || r.dest_mac == my_mac) && r.parse_ok) begin
          if (r.frame_type == arp_pkg::FT_IPV4) begin
            q.push_back(mk(arp_pkg::KIND_DELIVER, '0, r.handle, '0, '0));
          end else if (r.frame_type == arp_pkg::FT_ARP) begin
            c = cache_lookup(r.sender_ip);
            if (c < 0) begin
              c = pick_slot(ch_valid, ch_age);
              ch_valid[c] = 1'b1;
              ch_ip[c] = r.sender_ip;
            end
            ch_mac[c] = r.sender_mac;
            ch_age[c] = '0;
            if (r.arp_opcode == arp_pkg::OP_REQUEST) begin
              if (r.target_ip == my_ip)
                q.push_back(mk(arp_pkg::KIND_ARP_REPLY, r.sender_mac, '0, r.sender_mac,
                               r.sender_ip));
            end else if (r.arp_opcode == arp_pkg::OP_REPLY) begin
              // release waiting datagrams in arrival order, compact the rest
              for (int i = 0; i < wq_count; i++) begin
                if (wq_ip[i] == r.sender_ip) begin
                  q.push_back(mk(arp_pkg::KIND_IPV4, r.sender_mac, wq_handle[i], '0, '0));
                end else begin
                  wq_ip[k] = wq_ip[i];
                  wq_handle[k] = wq_handle[i];
                  k++;
                end
              end
              wq_count = k;
            end
          end
        end
      end
      arp_pkg::FUNC_TICK: begin
        // expire strictly above the lifetime
        for (int i = 0; i < NCACHE; i++) if (ch_valid[i]) begin
          s = {1'b0, ch_age[i]} + {1'b0, r.elapsed_ms};
          if (s > {1'b0, lifetime}) ch_valid[i] = 1'b0;
          else ch_age[i] = s[15:0];
        end
        for (int i = 0; i < NPEND; i++) if (pd_valid[i]) begin
          s = {1'b0, pd_age[i]} + {1'b0, r.elapsed_ms};
          if (s > {1'b0, holdoff}) pd_valid[i] = 1'b0;
          else pd_age[i] = s[15:0];
        end
      end
      default: ;
    endcase
    if (q.size() > 0) q[q.size()-1].last = 1'b1;
    if (typed) expected_results.push_back(typed_res);
    else foreach (q[i]) expected_results.push_back(q[i]);
  endtask

  // drive one item at the falling edge, hold it until accepted
  task automatic send_item(input arp_pkg::req_t r, input bit typed,
                           input arp_pkg::res_t typed_res);
    while ($urandom_range(99) < snd_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    func <= r.func;
    next_hop_ip <= r.next_hop_ip;
    datagram_handle <= r.handle;
    dest_mac <= r.dest_mac;
    frame_type <= r.frame_type;
    parse_ok <= r.parse_ok;
    arp_opcode <= r.arp_opcode;
    sender_mac <= r.sender_mac;
    sender_ip <= r.sender_ip;
    target_ip <= r.target_ip;
    elapsed_ms <= r.elapsed_ms;
    do @(posedge clk); while (!in_ready);
    resolve_item(r, typed, typed_res);
  endtask

  // wait for the block to go idle, then write all four registers
  task automatic configure(input logic [47:0] m, input logic [31:0] ip,
                           input logic [15:0] lt, input logic [15:0] ho);
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= arp_pkg::CFG_OWN_MAC;
    cfg_data <= m;
    @(negedge clk);
    cfg_index <= arp_pkg::CFG_OWN_IP;
    cfg_data <= {16'd0, ip};
    @(negedge clk);
    cfg_index <= arp_pkg::CFG_LIFETIME;
    cfg_data <= {32'd0, lt};
    @(negedge clk);
    cfg_index <= arp_pkg::CFG_HOLDOFF;
    cfg_data <= {32'd0, ho};
    @(negedge clk);
    cfg_we <= 1'b0;
    my_mac = m;
    my_ip = ip;
    lifetime = lt;
    holdoff = ho;
  endtask

  // mostly well-formed traffic around a small pool of hosts, some noise
  function automatic arp_pkg::req_t random_item();
    arp_pkg::req_t r;
    int k, h;
    k = $urandom_range(99);
    h = $urandom_range(19);
    r.func = arp_pkg::FUNC_RECV;
    r.next_hop_ip = ip_pool[h];
    r.handle = 16'($urandom);
    r.dest_mac = $urandom_range(1) ? arp_pkg::BCAST_MAC : my_mac;
    r.frame_type = arp_pkg::FT_ARP;
    r.parse_ok = 1'b1;
    r.arp_opcode = arp_pkg::OP_REPLY;
    r.sender_mac = mac_pool[h];
    r.sender_ip = ip_pool[h];
    r.target_ip = my_ip;
    r.elapsed_ms = 16'($urandom_range(3000));
    if (k < 35) begin
      r.func = arp_pkg::FUNC_SEND;
    end else if (k < 50) begin
      // reply from a pool host
    end else if (k < 58) begin
      r.arp_opcode = arp_pkg::OP_REQUEST;
      if ($urandom_range(3) == 0) r.target_ip = $urandom;
    end else if (k < 70) begin
      r.func = arp_pkg::FUNC_TICK;
      if ($urandom_range(5) == 0) r.elapsed_ms = 16'($urandom);
    end else if (k < 78) begin
      r.frame_type = arp_pkg::FT_IPV4;
    end else begin
      // noise, every field but dest_mac free; dest_mac random one time in three
      r.func = 2'($urandom);
      r.next_hop_ip = $urandom;
      r.dest_mac = $urandom_range(2) == 0 ? 48'({$urandom, $urandom}) : r.dest_mac;
      r.frame_type = 2'($urandom);
      r.parse_ok = 1'($urandom);
      r.arp_opcode = 2'($urandom);
      r.sender_mac = 48'({$urandom, $urandom});
      r.sender_ip = $urandom;
      r.target_ip = $urandom;
      r.elapsed_ms = 16'($urandom);
    end
    return r;
  endfunction

  // result checker, sampled at the rising edge
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: kind %0d handle %h", out_kind, out_handle);
      end else begin
        arp_pkg::res_t e;
        e = expected_results.pop_front();
        if (out_kind !== e.kind || out_dest_mac !== e.dest_mac ||
            out_handle !== e.handle || out_target_mac !== e.target_mac ||
            out_target_ip !== e.target_ip || last !== e.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch: exp kind %0d dmac %h h %h tmac %h tip %h last %b,",
                      " got kind %0d dmac %h h %h tmac %h tip %h last %b"},
                     e.kind, e.dest_mac, e.handle, e.target_mac, e.target_ip, e.last,
                     out_kind, out_dest_mac, out_handle, out_target_mac, out_target_ip,
                     last);
        end
      end
    end
  end

  // receiver: random stalls plus an occasional long hold-off
  always @(negedge clk) begin
    if (hold_gen != hold_seen) begin
      hold_seen = hold_gen;
      hold_cnt = HOLD_CYCLES;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rcv_pct);
    end
  end

  // watchdog on cycles with no handshake on either channel
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_arp_resolver_with_aging_unit failed");
      $finish;
    end
  end

  initial begin
    row_t          rows[$];
    row_t          w;
    arp_pkg::res_t none;
    arp_pkg::req_t z;
    logic [31:0] ha, hb;
    logic [47:0] ma;

    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = arp_pkg::CFG_OWN_MAC;
    cfg_data = '0;
    in_valid = 1'b0;
    out_ready = 1'b0;
    {func, next_hop_ip, datagram_handle, dest_mac, frame_type, parse_ok, arp_opcode,
     sender_mac, sender_ip, target_ip, elapsed_ms} = '0;
    snd_pct = 0;
    rcv_pct = 0;
    hold_gen = 0;
    hold_seen = 0;
    hold_cnt = 0;
    quiet_cycles = 0;
    mismatches = 0;
    my_mac = '0;
    my_ip = '0;
    lifetime = arp_pkg::LIFETIME_RST;
    holdoff = arp_pkg::HOLDOFF_RST;
    wq_count = 0;
    for (int i = 0; i < 16; i++) begin
      ch_valid[i] = 1'b0; ch_ip[i] = '0; ch_mac[i] = '0; ch_age[i] = '0;
      pd_valid[i] = 1'b0; pd_ip[i] = '0; pd_age[i] = '0;
      wq_ip[i] = '0; wq_handle[i] = '0;
    end
    for (int i = 0; i < 20; i++) begin
      ip_pool[i] = $urandom;
      mac_pool[i] = 48'({$urandom, $urandom});
    end
    ip_pool[0] = '0;
    ip_pool[1] = '1;
    mac_pool[0] = '1;
    mac_pool[1] = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed part, with the reset configuration (own mac 0, own ip 0)
    ha = 32'hC0A8_0001;
    hb = 32'h0A00_00FE;
    ma = 48'h0200_DEAD_BEEF;
    none = mk('0, '0, '0, '0, '0);
    z = '0;
    // send to an unknown ip after reset: one broadcast request
    w.r = z; w.r.func = arp_pkg::FUNC_SEND; w.r.next_hop_ip = ha; w.r.handle = 16'hFFFF;
    w.typed = 1'b1; w.res = mk(arp_pkg::KIND_ARP_REQ, arp_pkg::BCAST_MAC, '0, '0, ha);
    w.res.last = 1'b1;
    rows.push_back(w);
    // same ip again, still pending: queued silently
    w.r.handle = 16'h0000; w.typed = 1'b0; w.res = none; rows.push_back(w);
    // ipv4 frame to broadcast: delivered
    w.r = z; w.r.func = arp_pkg::FUNC_RECV; w.r.dest_mac = arp_pkg::BCAST_MAC;
    w.r.parse_ok = 1'b1; w.r.frame_type = arp_pkg::FT_IPV4; w.r.handle = 16'hA5A5;
    w.typed = 1'b1; w.res = mk(arp_pkg::KIND_DELIVER, '0, 16'hA5A5, '0, '0);
    w.res.last = 1'b1;
    rows.push_back(w);
    // ipv4 frame to own mac (0)
    w.r.dest_mac = '0; w.r.handle = 16'h5A5A;
    w.res = mk(arp_pkg::KIND_DELIVER, '0, 16'h5A5A, '0, '0); w.res.last = 1'b1;
    rows.push_back(w);
    // filtered: foreign mac, parse failure, other frame type
    w.typed = 1'b0; w.res = none;
    w.r.dest_mac = 48'h0000_0000_0001; rows.push_back(w);
    w.r.dest_mac = arp_pkg::BCAST_MAC; w.r.parse_ok = 1'b0; rows.push_back(w);
    w.r.parse_ok = 1'b1; w.r.frame_type = 2'd2; rows.push_back(w);
    // unknown func is ignored
    w.r = z; w.r.func = 2'd3; w.r.next_hop_ip = '1; rows.push_back(w);
    // arp request for own ip: answered, sender cached
    w.r = z; w.r.func = arp_pkg::FUNC_RECV; w.r.dest_mac = arp_pkg::BCAST_MAC;
    w.r.parse_ok = 1'b1; w.r.frame_type = arp_pkg::FT_ARP;
    w.r.arp_opcode = arp_pkg::OP_REQUEST; w.r.sender_mac = ma;
    w.r.sender_ip = hb; w.r.target_ip = '0;
    w.typed = 1'b1; w.res = mk(arp_pkg::KIND_ARP_REPLY, ma, '0, ma, hb);
    w.res.last = 1'b1;
    rows.push_back(w);
    // send to the cached host
    w.r = z; w.r.func = arp_pkg::FUNC_SEND; w.r.next_hop_ip = hb; w.r.handle = 16'h1234;
    w.res = mk(arp_pkg::KIND_IPV4, ma, 16'h1234, '0, '0); w.res.last = 1'b1;
    rows.push_back(w);
    // reply from the pending host releases both queued handles
    w.r = z; w.r.func = arp_pkg::FUNC_RECV; w.r.dest_mac = arp_pkg::BCAST_MAC;
    w.r.parse_ok = 1'b1; w.r.frame_type = arp_pkg::FT_ARP;
    w.r.arp_opcode = arp_pkg::OP_REPLY; w.r.sender_mac = '1;
    w.r.sender_ip = ha; w.typed = 1'b0; w.res = none; rows.push_back(w);
    // other opcode refreshes only; all-ones fields
    w.r.arp_opcode = 2'd2; w.r.sender_ip = '1; w.r.sender_mac = '1; w.r.target_ip = '1;
    rows.push_back(w);
    // tick at the hold-off boundary, then the largest tick expires everything
    w.r = z; w.r.func = arp_pkg::FUNC_TICK; w.r.elapsed_ms = 16'd5000; rows.push_back(w);
    w.r.elapsed_ms = 16'hFFFF; rows.push_back(w);
    w.r = z; w.r.func = arp_pkg::FUNC_SEND; w.r.next_hop_ip = hb; w.r.handle = 16'h0001;
    w.typed = 1'b1; w.res = mk(arp_pkg::KIND_ARP_REQ, arp_pkg::BCAST_MAC, '0, '0, hb);
    w.res.last = 1'b1;
    rows.push_back(w);
    // fill the wait store: the seventeenth queued datagram is dropped
    for (int i = 0; i < 16; i++) begin
      w.r.next_hop_ip = hb; w.r.handle = 16'h0100 + i[15:0]; w.typed = 1'b0;
      rows.push_back(w);
    end
    foreach (rows[i]) send_item(rows[i].r, rows[i].typed, rows[i].res);

    // random phases over several settings and idling patterns
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin configure(48'({$urandom, $urandom}), $urandom, arp_pkg::LIFETIME_RST,
                           arp_pkg::HOLDOFF_RST);
           snd_pct = 0; rcv_pct = 0; end
        1: begin configure('0, '0, '0, '0); snd_pct = 49; rcv_pct = 0; end
        2: begin configure('1, '1, '1, '1); snd_pct = 0; rcv_pct = 49;
           hold_gen++; end
        default: begin configure(mac_pool[5], ip_pool[7], 16'd1000, 16'd200);
           snd_pct = 16; rcv_pct = 16; end
      endcase
      for (int n = 0; n < ITEMS_PER_PHASE; n++) send_item(random_item(), 1'b0, none);
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("tb_arp_resolver_with_aging_unit passed");
    end else begin
      $display("tb_arp_resolver_with_aging_unit failed");
    end
    $finish;
  end

endmodule
